FILE: design/glr_pkg.sv
// Shared types, codes and helper functions for the genotype likelihood remap block.
// No dependencies; every other file in the design imports this package.
package glr_pkg;

    localparam int NUM_LIK   = 10;
    localparam int NUM_PAIRS = 10;
    localparam int NUM_BASES = 4;

    // Base codes produced by base_code().
    localparam logic [2:0] CODE_WILD  = 3'd4;
    localparam logic [2:0] CODE_OTHER = 3'd5;

    localparam logic [7:0] LIK_NONE = 8'hFF;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_LONG    = 3'd1,
        ST_BAD_REF = 3'd2,
        ST_NO_ALT  = 3'd3,
        ST_BAD_ALT = 3'd4
    } glr_status_t;

    typedef enum logic [2:0] {
        CFG_REF_BASE   = 3'd0,
        CFG_REF_SINGLE = 3'd1,
        CFG_ALT_COUNT  = 3'd2,
        CFG_ALT_FIRST  = 3'd3,
        CFG_ALT_SECOND = 3'd4,
        CFG_ALT_THIRD  = 3'd5,
        CFG_ALT_SINGLE = 3'd6
    } glr_cfg_index_t;

    typedef struct packed {
        logic [7:0] lik_in_0;
        logic [7:0] lik_in_1;
        logic [7:0] lik_in_2;
        logic [7:0] lik_in_3;
        logic [7:0] lik_in_4;
        logic [7:0] lik_in_5;
        logic [7:0] lik_in_6;
        logic [7:0] lik_in_7;
        logic [7:0] lik_in_8;
        logic [7:0] lik_in_9;
        logic       sample_last;
    } glr_in_t;

    typedef struct packed {
        logic [7:0] pair_lik_0;
        logic [7:0] pair_lik_1;
        logic [7:0] pair_lik_2;
        logic [7:0] pair_lik_3;
        logic [7:0] pair_lik_4;
        logic [7:0] pair_lik_5;
        logic [7:0] pair_lik_6;
        logic [7:0] pair_lik_7;
        logic [7:0] pair_lik_8;
        logic [7:0] pair_lik_9;
        logic [2:0] remap_status;
        logic       result_last;
    } glr_out_t;

    typedef struct packed {
        logic [7:0] ref_base;
        logic       ref_single;
        logic [2:0] alt_count;
        logic [7:0] alt_base_first;
        logic [7:0] alt_base_second;
        logic [7:0] alt_base_third;
        logic       alt_all_single;
    } glr_cfg_t;

    // Per-record selection plan: which input entry feeds each output pair.
    typedef struct packed {
        glr_status_t                 status;
        logic [NUM_PAIRS-1:0]        pair_none;
        logic [NUM_PAIRS-1:0][3:0]   pair_sel;
    } glr_plan_t;

    // Bases of each output pair, in the order AA, AC, AG, AT, CC, CG, CT, GG, GT, TT.
    localparam logic [NUM_PAIRS-1:0][1:0] PAIR_LO =
        {2'd3, 2'd2, 2'd2, 2'd1, 2'd1, 2'd1, 2'd0, 2'd0, 2'd0, 2'd0};
    localparam logic [NUM_PAIRS-1:0][1:0] PAIR_HI =
        {2'd3, 2'd3, 2'd2, 2'd3, 2'd2, 2'd1, 2'd3, 2'd2, 2'd1, 2'd0};

    function automatic logic [2:0] base_code(input logic [7:0] c);
        logic [2:0] code;
        case (c)
            8'h41, 8'h61: code = 3'd0;
            8'h43, 8'h63: code = 3'd1;
            8'h47, 8'h67: code = 3'd2;
            8'h54, 8'h74: code = 3'd3;
            8'h58, 8'h78: code = CODE_WILD;
            default:      code = CODE_OTHER;
        endcase
        return code;
    endfunction

    // Triangular position y(y+1)/2 + x for alleles x <= y.
    function automatic logic [3:0] tri_index(input logic [1:0] x, input logic [1:0] y);
        logic [3:0] base;
        case (y)
            2'd0:    base = 4'd0;
            2'd1:    base = 4'd1;
            2'd2:    base = 4'd3;
            default: base = 4'd6;
        endcase
        return base + {2'b00, x};
    endfunction

endpackage

FILE: design/glr_cfg.sv
// Configuration register file for the genotype likelihood remap block.
// Depends on glr_pkg for the register index codes and the config struct.
module glr_cfg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [7:0]          cfg_data,
    output glr_pkg::glr_cfg_t   cfg
);
    import glr_pkg::*;

    glr_cfg_t cfg_reg;
    glr_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (glr_cfg_index_t'(cfg_index))
                CFG_REF_BASE:   cfg_next.ref_base        = cfg_data;
                CFG_REF_SINGLE: cfg_next.ref_single      = cfg_data[0];
                CFG_ALT_COUNT:  cfg_next.alt_count       = cfg_data[2:0];
                CFG_ALT_FIRST:  cfg_next.alt_base_first  = cfg_data;
                CFG_ALT_SECOND: cfg_next.alt_base_second = cfg_data;
                CFG_ALT_THIRD:  cfg_next.alt_base_third  = cfg_data;
                CFG_ALT_SINGLE: cfg_next.alt_all_single  = cfg_data[0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ref_base        <= 8'd65;
            cfg_reg.ref_single      <= 1'b1;
            cfg_reg.alt_count       <= 3'd1;
            cfg_reg.alt_base_first  <= 8'd88;
            cfg_reg.alt_base_second <= 8'd0;
            cfg_reg.alt_base_third  <= 8'd0;
            cfg_reg.alt_all_single  <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: design/glr_plan.sv
// Record decoder: checks the record description and builds the pair selection plan.
// Depends on glr_pkg for base codes, pair tables and the plan struct.
module glr_plan (
    input  glr_pkg::glr_cfg_t   cfg,
    output glr_pkg::glr_plan_t  plan
);
    import glr_pkg::*;

    logic [2:0]                  ref_code;
    logic [2:0][2:0]             alt_code;
    logic [2:0]                  alt_used;
    logic                        alt_bad;
    logic                        wild_ok;
    logic [1:0]                  wild_allele;
    logic [NUM_BASES-1:0]        map_ok;
    logic [NUM_BASES-1:0][1:0]   map_allele;
    logic [1:0]                  x;
    logic [1:0]                  y;

    assign ref_code    = base_code(cfg.ref_base);
    assign alt_code[0] = base_code(cfg.alt_base_first);
    assign alt_code[1] = base_code(cfg.alt_base_second);
    assign alt_code[2] = base_code(cfg.alt_base_third);

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            alt_used[k] = 3'(k) < cfg.alt_count;
        end
    end

    always_comb
    begin
        alt_bad = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            if (alt_used[k] && alt_code[k] == CODE_OTHER)
            begin
                alt_bad = 1'b1;
            end
        end
    end

    always_comb
    begin
        if (!cfg.ref_single || cfg.alt_count > 3'd3)
            plan.status = ST_LONG;
        else if (ref_code > 3'd3)
            plan.status = ST_BAD_REF;
        else if (cfg.alt_count == 3'd0)
            plan.status = ST_NO_ALT;
        else if (!cfg.alt_all_single || alt_bad)
            plan.status = ST_BAD_ALT;
        else
            plan.status = ST_OK;
    end

    // The last wildcard alternate wins, as does the last allele naming a base.
    always_comb
    begin
        wild_ok     = 1'b0;
        wild_allele = 2'd0;
        for (int k = 0; k < 3; k++)
        begin
            if (alt_used[k] && alt_code[k] == CODE_WILD)
            begin
                wild_ok     = 1'b1;
                wild_allele = 2'(k + 1);
            end
        end
    end

    always_comb
    begin
        for (int b = 0; b < NUM_BASES; b++)
        begin
            map_ok[b]     = ref_code == 3'(b);
            map_allele[b] = 2'd0;
            for (int k = 0; k < 3; k++)
            begin
                if (alt_used[k] && alt_code[k] == 3'(b))
                begin
                    map_ok[b]     = 1'b1;
                    map_allele[b] = 2'(k + 1);
                end
            end
            if (!map_ok[b])
            begin
                map_ok[b]     = wild_ok;
                map_allele[b] = wild_allele;
            end
        end
    end

    always_comb
    begin
        x = 2'd0;
        y = 2'd0;
        for (int j = 0; j < NUM_PAIRS; j++)
        begin
            x = map_allele[PAIR_LO[j]];
            y = map_allele[PAIR_HI[j]];
            plan.pair_none[j] = !(map_ok[PAIR_LO[j]] && map_ok[PAIR_HI[j]]);
            plan.pair_sel[j]  = (x <= y) ? tri_index(x, y) : tri_index(y, x);
        end
    end

endmodule

FILE: design/glr_core.sv
// Two-register datapath: input register, remap mux network, result register.
// Depends on glr_pkg for the beat structs and the selection plan.
module glr_core (
    input  logic                clk,
    input  logic                rst_n,
    input  glr_pkg::glr_plan_t  plan,
    input  logic                in_valid,
    output logic                in_ready,
    input  glr_pkg::glr_in_t    in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output glr_pkg::glr_out_t   out_data
);
    import glr_pkg::*;

    logic                        s1_valid_reg;
    logic                        s1_valid_next;
    glr_in_t                     s1_data_reg;
    logic                        s2_valid_reg;
    logic                        s2_valid_next;
    glr_out_t                    s2_data_reg;
    glr_out_t                    s2_data_next;
    logic                        in_take;
    logic                        s2_load;
    logic [NUM_LIK-1:0][7:0]     lik;
    logic [NUM_PAIRS-1:0][7:0]   pair;

    // The result stage frees up in the same cycle its beat leaves, so one beat a cycle flows while out_ready is high.
    assign s2_load  = s1_valid_reg && (!s2_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s2_load;
    assign in_take  = in_valid && in_ready;

    assign s1_valid_next = in_take || (s1_valid_reg && !s2_load);
    assign s2_valid_next = s2_load || (s2_valid_reg && !out_ready);

    assign lik = {s1_data_reg.lik_in_9, s1_data_reg.lik_in_8, s1_data_reg.lik_in_7,
                  s1_data_reg.lik_in_6, s1_data_reg.lik_in_5, s1_data_reg.lik_in_4,
                  s1_data_reg.lik_in_3, s1_data_reg.lik_in_2, s1_data_reg.lik_in_1,
                  s1_data_reg.lik_in_0};

    always_comb
    begin
        for (int j = 0; j < NUM_PAIRS; j++)
        begin
            if (plan.status != ST_OK)
                pair[j] = 8'd0;
            else if (plan.pair_none[j])
                pair[j] = LIK_NONE;
            else
                pair[j] = lik[plan.pair_sel[j]];
        end
    end

    always_comb
    begin
        s2_data_next.pair_lik_0   = pair[0];
        s2_data_next.pair_lik_1   = pair[1];
        s2_data_next.pair_lik_2   = pair[2];
        s2_data_next.pair_lik_3   = pair[3];
        s2_data_next.pair_lik_4   = pair[4];
        s2_data_next.pair_lik_5   = pair[5];
        s2_data_next.pair_lik_6   = pair[6];
        s2_data_next.pair_lik_7   = pair[7];
        s2_data_next.pair_lik_8   = pair[8];
        s2_data_next.pair_lik_9   = pair[9];
        s2_data_next.remap_status = plan.status;
        s2_data_next.result_last  = s1_data_reg.sample_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_data_reg <= in_data;
        end
        if (s2_load)
        begin
            s2_data_reg <= s2_data_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_data  = s2_data_reg;

endmodule

FILE: design/genotype_likelihood_remap.sv
// Genotype likelihood remap: triangular allele likelihoods to the ten ACGT pairs.
// Path: an accepted beat passes through the input register, then the result register, to the output.
// Throughput: one beat per cycle while out_ready is high, set by the input register and result register.
// Reset (rst_n, asynchronous, active low) empties both stages and loads register defaults.
// Depends on glr_pkg, glr_cfg, glr_plan and glr_core.
module genotype_likelihood_remap (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  glr_pkg::glr_in_t    in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output glr_pkg::glr_out_t   out_data,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [7:0]          cfg_data
);
    import glr_pkg::*;

    glr_cfg_t  cfg;
    glr_plan_t plan;

    glr_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    glr_plan u_plan (
        .cfg  (cfg),
        .plan (plan)
    );

    glr_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .plan      (plan),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
